/* src/splb_pkg.sv */
// ----------------------------------------------------------------------------
// splb_pkg: shared types and codes of the sorted price-level book
// Level entry, per-cell flags, command and status codes, cell controls.
// ----------------------------------------------------------------------------
`default_nettype none

package splb_pkg;

    localparam int DEF_LEVEL_CAPACITY = 256;

    localparam int PRICE_W = 24;
    localparam int QTY_W   = 32;
    localparam int INDEX_W = 8;
    localparam int STAT_W  = 3;
    localparam int CMD_W   = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LEVEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_READ     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_UPDATED  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_REMOVED  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_IGNORED  = 3'd4;
    localparam logic [STAT_W-1:0] STAT_EVICTED  = 3'd5;
    localparam logic [STAT_W-1:0] STAT_DROPPED  = 3'd6;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } entry_t;

    typedef struct packed {
        logic ahead;    // valid level ranked ahead of the request price
        logic eq;       // valid level with the request price
        logic sel;      // valid level at the read index
    } flags_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef struct packed {
        logic               capture;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [INDEX_W-1:0] level_index;
    } scan_t;

    typedef struct packed {
        logic               en;
        logic               side;
        op_t                op;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } apply_t;

endpackage

`default_nettype wire

/* src/sorted_price_level_book_unit.sv */
// Each accepted request passes in order through the cell compare at the accept,
// the chain reduction, the cell shift and the output register.
// A new request is taken only once the previous one has finished its
// compare-reduce-shift sequence; a full output register holds the shift step.
// Reset: both level counts go to zero; stored levels are not cleared.
// ----------------------------------------------------------------------------
// sorted_price_level_book_unit: sorted bid/ask price-level book
// Chain of rank cells per side with insert, overwrite, remove, evict and read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_price_level_book_unit #(
    parameter int LEVEL_CAPACITY = splb_pkg::DEF_LEVEL_CAPACITY
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // price[23:0], qty[55:24], level_index[63:56]
    input  wire logic [2:0]  s_tuser,   // cmd[1:0], side[2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // out_index[7:0], out_price[31:8],
                                        // out_qty[63:32], present[64], zero[71:65]
    output logic [3:0]       m_tuser    // out_side[0], status[3:1]
);
    import splb_pkg::*;

    localparam int CNT_W = $clog2(LEVEL_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(LEVEL_CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_REDUCE = 3'b010,
        ST_APPLY  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // request fields
    logic [CMD_W-1:0]   s_cmd;
    logic               s_side;
    logic [PRICE_W-1:0] s_price;
    logic [QTY_W-1:0]   s_qty;
    logic [INDEX_W-1:0] s_level_index;
    logic               accept;

    logic [CMD_W-1:0]   cmd_reg;
    logic               side_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [QTY_W-1:0]   qty_reg;
    logic [INDEX_W-1:0] level_index_reg;

    logic [CNT_W-1:0] bid_cnt_reg, bid_cnt_next;
    logic [CNT_W-1:0] ask_cnt_reg, ask_cnt_next;
    logic [CNT_W-1:0] scan_n;
    logic [CNT_W-1:0] n_cur;

    scan_t  scan;
    apply_t apply;
    entry_t cell_entry [LEVEL_CAPACITY];
    flags_t cell_flags [LEVEL_CAPACITY];
    logic [LEVEL_CAPACITY-1:0] eq_vec;
    logic [LEVEL_CAPACITY-1:0] sel_vec;

    logic [CNT_W-1:0] red_pos;
    logic             red_found;
    logic             red_hit;
    entry_t           red_entry;
    logic [31:0]      pos_w;

    // decision of the reduce step
    logic               dec_emit;
    logic               dec_clear;
    op_t                dec_op;
    logic [CNT_W-1:0]   dec_cnt;
    logic [INDEX_W-1:0] dec_index;
    logic [PRICE_W-1:0] dec_price;
    logic [QTY_W-1:0]   dec_qty;
    logic               dec_present;
    logic [STAT_W-1:0]  dec_status;

    logic               pend_emit_reg;
    logic               pend_clear_reg;
    op_t                pend_op_reg;
    logic [CNT_W-1:0]   pend_pos_reg;
    logic [CNT_W-1:0]   pend_cnt_reg;
    logic [INDEX_W-1:0] pend_index_reg;
    logic [PRICE_W-1:0] pend_price_reg;
    logic [QTY_W-1:0]   pend_qty_reg;
    logic               pend_present_reg;
    logic [STAT_W-1:0]  pend_status_reg;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [71:0] m_tdata_reg;
    logic [3:0]  m_tuser_reg;
    logic        go;

    assign s_cmd         = s_tuser[1:0];
    assign s_side        = s_tuser[2];
    assign s_price       = s_tdata[23:0];
    assign s_qty         = s_tdata[55:24];
    assign s_level_index = s_tdata[63:56];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign scan_n = s_side ? ask_cnt_reg : bid_cnt_reg;
    assign n_cur  = side_reg ? ask_cnt_reg : bid_cnt_reg;

    always_comb begin
        scan.capture     = accept;
        scan.side        = s_side;
        scan.price       = s_price;
        scan.level_index = s_level_index;
    end

    // shift step waits only for a free output register
    assign go = (state_reg == ST_APPLY) && (!pend_emit_reg || !m_tvalid_reg || m_tready);

    always_comb begin
        apply.en    = go;
        apply.side  = side_reg;
        apply.op    = pend_op_reg;
        apply.price = price_reg;
        apply.qty   = qty_reg;
    end

    // cell chain
    for (genvar i = 0; i < LEVEL_CAPACITY; i++) begin : g_cell
        entry_t left_e;
        entry_t right_e;
        if (i == 0) begin : g_first
            assign left_e = '0;
        end else begin : g_mid
            assign left_e = cell_entry[i-1];
        end
        if (i == LEVEL_CAPACITY - 1) begin : g_last
            assign right_e = cell_entry[i];
        end else begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        splb_cell #(
            .LEVEL_CAPACITY (LEVEL_CAPACITY),
            .CELL_INDEX     (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .scan_i   (scan),
            .scan_n_i (scan_n),
            .apply_i  (apply),
            .pos_i    (pend_pos_reg),
            .left_i   (left_e),
            .right_i  (right_e),
            .entry_o  (cell_entry[i]),
            .flags_o  (cell_flags[i])
        );

        assign eq_vec[i]  = cell_flags[i].eq;
        assign sel_vec[i] = cell_flags[i].sel;
    end

    splb_reduce #(
        .LEVEL_CAPACITY (LEVEL_CAPACITY)
    ) u_reduce (
        .flags_i    (cell_flags),
        .entries_i  (cell_entry),
        .pos_o      (red_pos),
        .found_o    (red_found),
        .rd_hit_o   (red_hit),
        .rd_entry_o (red_entry)
    );

    assign pos_w = 32'(red_pos);

    always_comb begin
        dec_emit    = 1'b0;
        dec_clear   = 1'b0;
        dec_op      = OP_NONE;
        dec_cnt     = n_cur;
        dec_index   = pos_w[7:0];
        dec_price   = price_reg;
        dec_qty     = '0;
        dec_present = 1'b0;
        dec_status  = STAT_READ;
        case (cmd_reg)
            CMD_CLEAR: begin
                dec_clear = 1'b1;
            end
            CMD_READ: begin
                dec_emit    = 1'b1;
                dec_index   = level_index_reg;
                dec_price   = red_entry.price;
                dec_qty     = red_entry.qty;
                dec_present = red_hit;
                dec_status  = STAT_READ;
            end
            CMD_LEVEL: begin
                dec_emit = 1'b1;
                if (red_found) begin
                    if (qty_reg != '0) begin
                        dec_op      = OP_WRITE;
                        dec_qty     = qty_reg;
                        dec_present = 1'b1;
                        dec_status  = STAT_UPDATED;
                    end else begin
                        dec_op     = OP_REMOVE;
                        dec_cnt    = n_cur - CNT_W'(1);
                        dec_status = STAT_REMOVED;
                    end
                end else if (qty_reg == '0) begin
                    dec_status = STAT_IGNORED;
                end else if (n_cur >= CAP) begin
                    if (red_pos >= CAP) begin
                        dec_status = STAT_DROPPED;
                    end else begin
                        // last cell falls off the end of the chain
                        dec_op      = OP_INSERT;
                        dec_qty     = qty_reg;
                        dec_present = 1'b1;
                        dec_status  = STAT_EVICTED;
                    end
                end else begin
                    dec_op      = OP_INSERT;
                    dec_cnt     = n_cur + CNT_W'(1);
                    dec_qty     = qty_reg;
                    dec_present = 1'b1;
                    dec_status  = STAT_INSERTED;
                end
            end
            default: begin
                dec_emit = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        bid_cnt_next = bid_cnt_reg;
        ask_cnt_next = ask_cnt_reg;
        if (go) begin
            if (pend_clear_reg) begin
                bid_cnt_next = '0;
                ask_cnt_next = '0;
            end else if (side_reg) begin
                ask_cnt_next = pend_cnt_reg;
            end else begin
                bid_cnt_next = pend_cnt_reg;
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (go && pend_emit_reg) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            bid_cnt_reg    <= '0;
            ask_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            pend_emit_reg  <= 1'b0;
            pend_clear_reg <= 1'b0;
            pend_op_reg    <= OP_NONE;
        end else begin
            state_reg    <= state_next;
            bid_cnt_reg  <= bid_cnt_next;
            ask_cnt_reg  <= ask_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (state_reg == ST_REDUCE) begin
                pend_emit_reg  <= dec_emit;
                pend_clear_reg <= dec_clear;
                pend_op_reg    <= dec_op;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg         <= s_cmd;
            side_reg        <= s_side;
            price_reg       <= s_price;
            qty_reg         <= s_qty;
            level_index_reg <= s_level_index;
        end
        if (state_reg == ST_REDUCE) begin
            pend_pos_reg     <= red_pos;
            pend_cnt_reg     <= dec_cnt;
            pend_index_reg   <= dec_index;
            pend_price_reg   <= dec_price;
            pend_qty_reg     <= dec_qty;
            pend_present_reg <= dec_present;
            pend_status_reg  <= dec_status;
        end
        if (go && pend_emit_reg) begin
            m_tdata_reg <= {7'b0, pend_present_reg, pend_qty_reg, pend_price_reg,
                            pend_index_reg};
            m_tuser_reg <= {pend_status_reg, side_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // prices on a side are distinct, so at most one cell matches
    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REDUCE) |-> $onehot0(eq_vec))
        else $error("more than one level matches the request price");

    a_single_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REDUCE) |-> $onehot0(sel_vec))
        else $error("more than one cell selected by a read");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (bid_cnt_reg <= CAP) && (ask_cnt_reg <= CAP))
        else $error("level count beyond capacity");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && pend_emit_reg) |=> (m_tvalid_reg && (state_reg == ST_IDLE)))
        else $error("result not presented after shift step");

endmodule

`default_nettype wire

/* src/splb_cell.sv */
// ----------------------------------------------------------------------------
// splb_cell: one rank of the price-level chain
// Holds the bid and ask level of its rank, flags its compare result against
// a request, and shifts to or from its neighbors when a level moves.
// ----------------------------------------------------------------------------
`default_nettype none

module splb_cell #(
    parameter int LEVEL_CAPACITY = splb_pkg::DEF_LEVEL_CAPACITY,
    parameter int CELL_INDEX     = 0,
    localparam int CNT_W         = $clog2(LEVEL_CAPACITY + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire splb_pkg::scan_t   scan_i,
    input  wire logic [CNT_W-1:0]  scan_n_i,
    input  wire splb_pkg::apply_t  apply_i,
    input  wire logic [CNT_W-1:0]  pos_i,
    input  wire splb_pkg::entry_t  left_i,
    input  wire splb_pkg::entry_t  right_i,
    output splb_pkg::entry_t       entry_o,
    output splb_pkg::flags_t       flags_o
);
    import splb_pkg::*;

    localparam logic [CNT_W-1:0]   MY_POS   = CNT_W'(CELL_INDEX);
    localparam bit                 READABLE = (CELL_INDEX < 256);
    localparam logic [INDEX_W-1:0] MY_IDX8  = INDEX_W'(CELL_INDEX % 256);

    entry_t bid_reg, bid_next;
    entry_t ask_reg, ask_next;
    flags_t flags_reg, flags_next;
    entry_t scan_entry;
    entry_t own;
    entry_t upd;
    logic   valid;
    logic   at_pos;
    logic   after_pos;

    // compare stage
    always_comb begin
        scan_entry = scan_i.side ? ask_reg : bid_reg;
        valid      = MY_POS < scan_n_i;
        flags_next.ahead = valid && (scan_i.side ? (scan_entry.price < scan_i.price)
                                                 : (scan_entry.price > scan_i.price));
        flags_next.eq  = valid && (scan_entry.price == scan_i.price);
        flags_next.sel = READABLE && valid && (scan_i.level_index == MY_IDX8);
    end

    // shift / write stage
    always_comb begin
        own       = apply_i.side ? ask_reg : bid_reg;
        at_pos    = (pos_i == MY_POS);
        after_pos = (MY_POS > pos_i);
        upd       = own;
        case (apply_i.op)
            OP_WRITE: begin
                if (at_pos) begin
                    upd.qty = apply_i.qty;
                end
            end
            OP_INSERT: begin
                if (at_pos) begin
                    upd.price = apply_i.price;
                    upd.qty   = apply_i.qty;
                end else if (after_pos) begin
                    upd = left_i;
                end
            end
            OP_REMOVE: begin
                if (at_pos || after_pos) begin
                    upd = right_i;
                end
            end
            default: begin
                upd = own;
            end
        endcase
        bid_next = (apply_i.en && !apply_i.side) ? upd : bid_reg;
        ask_next = (apply_i.en &&  apply_i.side) ? upd : ask_reg;
    end

    always_ff @(posedge aclk) begin
        bid_reg <= bid_next;
        ask_reg <= ask_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (scan_i.capture) begin
            flags_reg <= flags_next;
        end
    end

    assign entry_o = own;
    assign flags_o = flags_reg;

endmodule

`default_nettype wire

/* src/splb_reduce.sv */
// ----------------------------------------------------------------------------
// splb_reduce: chain-wide reduction of the cell flags
// Finds the insertion rank from the ahead flags, the price match, and the
// level selected by a read.
// ----------------------------------------------------------------------------
`default_nettype none

module splb_reduce #(
    parameter int LEVEL_CAPACITY = splb_pkg::DEF_LEVEL_CAPACITY,
    localparam int CNT_W         = $clog2(LEVEL_CAPACITY + 1)
) (
    input  wire splb_pkg::flags_t  flags_i   [LEVEL_CAPACITY],
    input  wire splb_pkg::entry_t  entries_i [LEVEL_CAPACITY],
    output logic [CNT_W-1:0]       pos_o,
    output logic                   found_o,
    output logic                   rd_hit_o,
    output splb_pkg::entry_t       rd_entry_o
);
    import splb_pkg::*;

    logic             bnd;
    logic             any_bnd;
    logic [CNT_W-1:0] pos_or;

    always_comb begin
        any_bnd    = 1'b0;
        pos_or     = '0;
        found_o    = 1'b0;
        rd_hit_o   = 1'b0;
        rd_entry_o = '0;
        bnd        = 1'b0;
        for (int i = 0; i < LEVEL_CAPACITY; i++) begin
            // first cell not ranked ahead, right after one that is
            if (i == 0) begin
                bnd = !flags_i[i].ahead;
            end else begin
                bnd = flags_i[i-1].ahead && !flags_i[i].ahead;
            end
            any_bnd = any_bnd | bnd;
            pos_or  = pos_or | (bnd ? CNT_W'(i) : '0);
            found_o = found_o | flags_i[i].eq;
            rd_hit_o = rd_hit_o | flags_i[i].sel;
            rd_entry_o = rd_entry_o | (flags_i[i].sel ? entries_i[i] : '0);
        end
        // every slot filled and ahead of the price
        pos_o = any_bnd ? pos_or : CNT_W'(LEVEL_CAPACITY);
    end

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted price-level book
// Drives clear, level, read and spare-code requests on the input stream, predicts every
// result from a private copy of both level tables and compares each returned
// level field by field, under several idle and back-pressure patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import splb_pkg::*;

    localparam int BOOK_DEPTH    = DEF_LEVEL_CAPACITY;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD     = 120;
    localparam int TIMEOUT_NS    = 600000;

    localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
    localparam logic               SIDE_BID   = 1'b0;
    localparam logic               SIDE_ASK   = 1'b1;
    localparam logic [PRICE_W-1:0] PRICE_MAX  = {PRICE_W{1'b1}};
    localparam logic [QTY_W-1:0]   QTY_MAX    = {QTY_W{1'b1}};
    // fill prices keep room on both sides of the book for worse levels
    localparam int unsigned        FILL_LO    = 1000;
    localparam int unsigned        FILL_HI    = 24'hEFFFFF;
    localparam int unsigned        POOL_BASE  = 5000;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [INDEX_W-1:0] level_index;
    } book_req_t;

    typedef struct packed {
        logic               side;
        logic [INDEX_W-1:0] rank;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic               present;
        logic [STAT_W-1:0]  status;
    } level_res_t;

    class book_scoreboard;
        logic [PRICE_W-1:0] lvl_price [2][BOOK_DEPTH];
        logic [QTY_W-1:0]   lvl_qty   [2][BOOK_DEPTH];
        int unsigned        lvl_count [2];
        level_res_t         expected_q [$];
        int unsigned        mismatches;
        int unsigned        requests;
        int unsigned        checked;
        int unsigned        status_seen [8];

        task report_mismatch(string what, longint unsigned got,
                             longint unsigned want);
            mismatches++;
            $display("[%0t] book result %0d: %s got 0x%0h expected 0x%0h",
                     $time, checked, what, got, want);
        endtask

        function void push_expected(logic side, int unsigned rank,
                                    logic [PRICE_W-1:0] price, logic [QTY_W-1:0] qty,
                                    logic present, logic [STAT_W-1:0] status);
            level_res_t e;
            e.side    = side;
            e.rank    = INDEX_W'(rank);
            e.price   = price;
            e.qty     = qty;
            e.present = present;
            e.status  = status;
            expected_q = {expected_q, e};
        endfunction

        // bids rank highest first, asks lowest first
        function bit ranks_ahead(logic [PRICE_W-1:0] held, logic [PRICE_W-1:0] price,
                                 logic side);
            return side ? (held < price) : (held > price);
        endfunction

        function void note_request(book_req_t r);
            int unsigned s;
            int unsigned n;
            int unsigned pos;
            int unsigned k;
            requests++;
            s = r.side;
            n = lvl_count[s];
            if (r.cmd == CMD_CLEAR) begin
                lvl_count[0] = 0;
                lvl_count[1] = 0;
                return;
            end
            if (r.cmd == CMD_READ) begin
                if (r.level_index < n)
                    push_expected(r.side, r.level_index, lvl_price[s][r.level_index],
                                  lvl_qty[s][r.level_index], 1'b1, STAT_READ);
                else
                    push_expected(r.side, r.level_index, '0, '0, 1'b0, STAT_READ);
                return;
            end
            if (r.cmd != CMD_LEVEL)
                return;

            pos = 0;
            while (pos < n && ranks_ahead(lvl_price[s][pos], r.price, r.side))
                pos++;

            if (pos < n && lvl_price[s][pos] == r.price) begin
                if (r.qty != '0) begin
                    lvl_qty[s][pos] = r.qty;
                    push_expected(r.side, pos, r.price, r.qty, 1'b1, STAT_UPDATED);
                end else begin
                    for (k = pos; k + 1 < n; k++) begin
                        lvl_price[s][k] = lvl_price[s][k+1];
                        lvl_qty[s][k]   = lvl_qty[s][k+1];
                    end
                    lvl_count[s] = n - 1;
                    push_expected(r.side, pos, r.price, '0, 1'b0, STAT_REMOVED);
                end
            end else if (r.qty == '0) begin
                push_expected(r.side, pos, r.price, '0, 1'b0, STAT_IGNORED);
            end else if (n >= BOOK_DEPTH) begin
                if (pos >= BOOK_DEPTH) begin
                    push_expected(r.side, BOOK_DEPTH, r.price, '0, 1'b0, STAT_DROPPED);
                end else begin
                    // worst level falls off the end
                    for (k = BOOK_DEPTH - 1; k > pos; k--) begin
                        lvl_price[s][k] = lvl_price[s][k-1];
                        lvl_qty[s][k]   = lvl_qty[s][k-1];
                    end
                    lvl_price[s][pos] = r.price;
                    lvl_qty[s][pos]   = r.qty;
                    push_expected(r.side, pos, r.price, r.qty, 1'b1, STAT_EVICTED);
                end
            end else begin
                for (k = n; k > pos; k--) begin
                    lvl_price[s][k] = lvl_price[s][k-1];
                    lvl_qty[s][k]   = lvl_qty[s][k-1];
                end
                lvl_price[s][pos] = r.price;
                lvl_qty[s][pos]   = r.qty;
                lvl_count[s] = n + 1;
                push_expected(r.side, pos, r.price, r.qty, 1'b1, STAT_INSERTED);
            end
        endfunction

        task check_result(level_res_t got);
            level_res_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing pending", 64'(got.price), 64'd0);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got.side != want.side)
                report_mismatch("out_side", 64'(got.side), 64'(want.side));
            if (got.rank != want.rank)
                report_mismatch("out_index", 64'(got.rank), 64'(want.rank));
            if (got.price != want.price)
                report_mismatch("out_price", 64'(got.price), 64'(want.price));
            if (got.qty != want.qty)
                report_mismatch("out_qty", 64'(got.qty), 64'(want.qty));
            if (got.present != want.present)
                report_mismatch("present", 64'(got.present), 64'(want.present));
            if (got.status != want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
        endtask
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [63:0]         s_tdata;   // price[23:0], qty[55:24], level_index[63:56]
    logic [2:0]          s_tuser;   // cmd[1:0], side[2]
    logic                m_tvalid;
    logic                m_tready;
    logic [71:0]         m_tdata;   // out_index[7:0], out_price[31:8], out_qty[63:32],
                                    // present[64], zero[71:65]
    logic [3:0]          m_tuser;   // out_side[0], status[3:1]

    book_scoreboard      sb = new();
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    int                  hold_requests = 0;
    int unsigned         items_sent = 0;

    sorted_price_level_book_unit #(
        .LEVEL_CAPACITY(BOOK_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        level_res_t got;
        book_req_t  req;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.rank    = m_tdata[7:0];
                got.price   = m_tdata[31:8];
                got.qty     = m_tdata[63:32];
                got.present = m_tdata[64];
                got.side    = m_tuser[0];
                got.status  = m_tuser[3:1];
                if (m_tdata[71:65] != '0)
                    sb.report_mismatch("m_tdata padding", 64'(m_tdata[71:65]), 64'd0);
                sb.check_result(got);
            end
            if (s_tvalid && s_tready) begin
                req.price       = s_tdata[23:0];
                req.qty         = s_tdata[55:24];
                req.level_index = s_tdata[63:56];
                req.cmd         = s_tuser[1:0];
                req.side        = s_tuser[2];
                sb.note_request(req);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off whenever the sender asks
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results still pending", sb.expected_q.size());
        $display("sorted_price_level_book_unit: mismatch");
        $finish;
    end

    function automatic book_req_t level_req(logic side, logic [PRICE_W-1:0] price,
                                            logic [QTY_W-1:0] qty);
        book_req_t r;
        r.cmd         = CMD_LEVEL;
        r.side        = side;
        r.price       = price;
        r.qty         = qty;
        r.level_index = INDEX_W'($urandom);
        return r;
    endfunction

    function automatic book_req_t read_req(logic side, logic [INDEX_W-1:0] idx);
        book_req_t r;
        r.cmd         = CMD_READ;
        r.side        = side;
        r.price       = PRICE_W'($urandom);
        r.qty         = $urandom;
        r.level_index = idx;
        return r;
    endfunction

    // clear and the spare code carry junk in every other field
    function automatic book_req_t junk_req(logic [CMD_W-1:0] cmd);
        book_req_t r;
        r.cmd         = cmd;
        r.side        = 1'($urandom_range(1));
        r.price       = PRICE_W'($urandom);
        r.qty         = $urandom;
        r.level_index = INDEX_W'($urandom);
        return r;
    endfunction

    function automatic logic [QTY_W-1:0] random_qty();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3)
            return QTY_MAX;
        if (r < 6)
            return QTY_W'(1);
        return $urandom;
    endfunction

    function automatic logic [PRICE_W-1:0] known_price(logic side);
        int unsigned n;
        n = sb.lvl_count[side];
        if (n == 0)
            return PRICE_W'(POOL_BASE + 10 * $urandom_range(31));
        return sb.lvl_price[side][$urandom_range(n - 1)];
    endfunction

    // mostly new levels on one side, so the side fills up, then evictions
    // and drops once it is full
    function automatic book_req_t fill_req(logic side);
        int unsigned        r;
        int unsigned        n;
        logic [PRICE_W-1:0] worst;
        logic [QTY_W-1:0]   qty;
        r = $urandom_range(99);
        n = sb.lvl_count[side];
        if (r < 5)
            return read_req(!side, INDEX_W'($urandom_range(255)));
        if (r < 12)
            return read_req(side, ($urandom_range(3) == 0) ? 8'hFF
                                                           : INDEX_W'($urandom_range(255)));
        if (r < 20 && n != 0) begin
            qty = ($urandom_range(2) == 0) ? '0 : random_qty();
            return level_req(side, known_price(side), qty);
        end
        if (n >= BOOK_DEPTH && r < 50) begin
            worst = sb.lvl_price[side][BOOK_DEPTH-1];
            qty = ($urandom_range(4) == 0) ? '0 : random_qty();
            if (side == SIDE_ASK)
                return level_req(side, PRICE_W'($urandom_range(PRICE_MAX, worst + 1)), qty);
            return level_req(side, PRICE_W'($urandom_range(worst - 1, 0)), qty);
        end
        qty = random_qty();
        if (qty == '0)
            qty = QTY_W'(1);
        return level_req(side, PRICE_W'($urandom_range(FILL_HI, FILL_LO)), qty);
    endfunction

    // small pool of prices so updates and removes hit often
    function automatic book_req_t mixed_req();
        int unsigned        r;
        int unsigned        n;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        r = $urandom_range(99);
        side = 1'($urandom_range(1));
        n = sb.lvl_count[side];
        if (r < 4)
            return junk_req(CMD_CLEAR);
        if (r < 6)
            return junk_req(CMD_UNUSED);
        if (r < 40) begin
            if (n != 0 && $urandom_range(1) == 1)
                return read_req(side, INDEX_W'($urandom_range(n - 1)));
            return read_req(side, INDEX_W'($urandom_range(255)));
        end
        r = $urandom_range(99);
        if (r < 55)
            price = PRICE_W'(POOL_BASE + 10 * $urandom_range(31));
        else if (r < 85)
            price = known_price(side);
        else if (r < 90)
            price = $urandom_range(1) ? PRICE_MAX : '0;
        else
            price = PRICE_W'($urandom_range(PRICE_MAX));
        qty = ($urandom_range(3) == 0) ? '0 : random_qty();
        return level_req(side, price, qty);
    endfunction

    task automatic send_request(book_req_t r);
        @(negedge aclk);
        s_tdata  <= {r.level_index, r.qty, r.price};
        s_tuser  <= {r.side, r.cmd};
        s_tvalid <= 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    task automatic park_sender();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tdata  <= {$urandom, $urandom};
    endtask

    task automatic paced_send(book_req_t r);
        while ($urandom_range(99) < send_idle_pct)
            park_sender();
        send_request(r);
        items_sent++;
    endtask

    // stop offering, wait for every pending level, then let clears settle
    task automatic drain_book();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned guard;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty reads, extreme prices and quantities, every status
        // that a small book reaches, the spare code, and a clear
        send_request(read_req(SIDE_BID, 8'd0));
        send_request(level_req(SIDE_BID, 24'd500, '0));
        send_request(level_req(SIDE_BID, '0, 32'd1));
        send_request(level_req(SIDE_BID, PRICE_MAX, QTY_MAX));
        send_request(level_req(SIDE_BID, 24'd100, 32'd5));
        send_request(level_req(SIDE_BID, 24'd100, 32'd7));
        send_request(read_req(SIDE_BID, 8'd0));
        send_request(read_req(SIDE_BID, 8'd1));
        send_request(read_req(SIDE_BID, 8'd2));
        send_request(read_req(SIDE_BID, 8'd3));
        send_request(read_req(SIDE_BID, 8'hFF));
        send_request(level_req(SIDE_BID, 24'd100, '0));
        send_request(level_req(SIDE_BID, 24'd50, '0));
        send_request(read_req(SIDE_BID, 8'd1));
        send_request(level_req(SIDE_ASK, PRICE_MAX, 32'd3));
        send_request(level_req(SIDE_ASK, '0, QTY_MAX));
        send_request(level_req(SIDE_ASK, 24'd300, 32'd9));
        send_request(read_req(SIDE_ASK, 8'd0));
        send_request(read_req(SIDE_ASK, 8'd2));
        send_request(junk_req(CMD_UNUSED));
        send_request(level_req(SIDE_ASK, 24'd300, '0));
        send_request(junk_req(CMD_CLEAR));
        send_request(read_req(SIDE_BID, 8'd0));
        send_request(read_req(SIDE_ASK, 8'd0));
        send_request(level_req(SIDE_ASK, 24'd7, 32'd1));
        send_request(read_req(SIDE_ASK, 8'd0));
        drain_book();

        // bid side to full and beyond, back to back
        send_idle_pct = 0;
        stall_pct = 0;
        guard = 0;
        while (sb.lvl_count[SIDE_BID] < BOOK_DEPTH && guard < 700) begin
            paced_send(fill_req(SIDE_BID));
            guard++;
        end
        repeat (60) paced_send(fill_req(SIDE_BID));

        // ask side to full with a slow sender and one full pause midway
        send_idle_pct = 68;
        guard = 0;
        while (sb.lvl_count[SIDE_ASK] < BOOK_DEPTH && guard < 700) begin
            if (guard == 150)
                drain_book();
            paced_send(fill_req(SIDE_ASK));
            guard++;
        end
        repeat (60) paced_send(fill_req(SIDE_ASK));

        // slow receiver, opening with a long hold-off under a steady sender
        send_idle_pct = 0;
        stall_pct = 68;
        hold_requests++;
        repeat (190) paced_send(mixed_req());

        send_idle_pct = 9;
        stall_pct = 9;
        repeat (150) paced_send(mixed_req());

        drain_book();
        $display("sent %0d requests (%0d accepted), checked %0d levels",
                 items_sent, sb.requests, sb.checked);
        $display({"read %0d updated %0d inserted %0d removed %0d ",
                  "ignored %0d evicted %0d dropped %0d"},
                 sb.status_seen[STAT_READ], sb.status_seen[STAT_UPDATED],
                 sb.status_seen[STAT_INSERTED], sb.status_seen[STAT_REMOVED],
                 sb.status_seen[STAT_IGNORED], sb.status_seen[STAT_EVICTED],
                 sb.status_seen[STAT_DROPPED]);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("sorted_price_level_book_unit: match");
        end else begin
            $display("sorted_price_level_book_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
